// ----- hdl/ata_pio_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Codes, status bits and the descriptor word passed from front to back end.
// ----------------------------------------------------------------------------
package ata_pio_pkg;

    localparam int QDEPTH = 2;
    localparam int SECTOR_WORDS_LOG2 = 8;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;

    localparam int ST_BSY_BIT = 7;
    localparam int ST_DF_BIT  = 5;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    localparam logic [2:0] ACT_REG_WR    = 3'd0;
    localparam logic [2:0] ACT_STAT_RD   = 3'd1;
    localparam logic [2:0] ACT_DATA_RD   = 3'd2;
    localparam logic [2:0] ACT_DATA_WR   = 3'd3;
    localparam logic [2:0] ACT_NEED_WORD = 3'd4;
    localparam logic [2:0] ACT_WORD_OUT  = 3'd5;
    localparam logic [2:0] ACT_DONE      = 3'd6;
    localparam logic [2:0] ACT_ABORT     = 3'd7;

    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_COUNT   = 3'd2;
    localparam logic [2:0] OFF_LBA_LO  = 3'd3;
    localparam logic [2:0] OFF_LBA_MID = 3'd4;
    localparam logic [2:0] OFF_LBA_HI  = 3'd5;
    localparam logic [2:0] OFF_DRIVE   = 3'd6;
    localparam logic [2:0] OFF_CMD     = 3'd7;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DRIVE_LBA = 8'hE0;

    typedef enum logic [2:0] {
        HEAD_NONE,
        HEAD_CMD,
        HEAD_ABORT,
        HEAD_WORD_OUT,
        HEAD_WORD_WR
    } head_t;

    typedef enum logic [2:0] {
        TAIL_POLL,
        TAIL_DONE,
        TAIL_NEED,
        TAIL_RREQ,
        TAIL_FLUSH
    } tail_t;

    // One queued job: an optional head group of results, then a tail group
    typedef struct packed {
        head_t        head;
        tail_t        tail;
        logic [15:0]  head_val;
        logic [39:0]  head_idx;
        logic [39:0]  tail_idx;
        logic [27:0]  lba;
        logic [7:0]   count;
        logic         dir;
    } desc_t;

endpackage
`default_nettype wire

// ----- hdl/ata_pio_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO front end
// Accepts items, tracks transfer state and queues at most one descriptor per item.
// ----------------------------------------------------------------------------
module ata_pio_front #(
    parameter int CHUNK_SECTORS = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic                s_write_dir,
    input  wire logic                s_use_partition,
    input  wire logic [31:0]         s_lba,
    input  wire logic [31:0]         s_sector_count,
    input  wire logic [7:0]          s_status_byte,
    input  wire logic [15:0]         s_data_word,
    input  wire logic                q_full,
    output logic                     q_push,
    output ata_pio_pkg::desc_t       q_wdata
);
    import ata_pio_pkg::*;

    localparam logic [8:0] CHUNK_W = 9'(CHUNK_SECTORS);

    typedef enum logic [2:0] {
        PH_IDLE, PH_BSY_PRE, PH_DRQ, PH_RDATA, PH_WDATA, PH_FLUSH
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         dir_reg, dir_next;
    logic [31:0]  part_reg;
    logic [31:0]  lba_reg, lba_next;
    logic [31:0]  total_reg, total_next;
    logic [8:0]   chunk_reg, chunk_next;
    logic [8:0]   slc_reg, slc_next;
    logic [7:0]   wc_reg, wc_next;
    logic [39:0]  base_reg, base_next;
    logic [39:0]  wi_reg, wi_next;

    logic         accept, do_finish;
    logic [31:0]  start_lba, fin_total, fin_lba;
    logic [39:0]  fin_wi, wi_inc;
    logic [8:0]   slc_dec;

    function automatic logic [8:0] chunk_of(input logic [31:0] total);
        return (total < 32'(CHUNK_W)) ? total[8:0] : CHUNK_W;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign start_lba = s_lba + (s_use_partition ? part_reg : 32'd0);
    assign fin_total = total_reg - {23'd0, chunk_reg};
    assign fin_lba   = lba_reg + {23'd0, chunk_reg};
    assign fin_wi    = base_reg + {23'd0, chunk_reg, 8'd0};
    assign wi_inc    = wi_reg + 40'd1;
    assign slc_dec   = (slc_reg != 9'd0) ? slc_reg - 9'd1 : 9'd0;

    always_comb begin
        phase_next = phase_reg;
        dir_next   = dir_reg;
        lba_next   = lba_reg;
        total_next = total_reg;
        chunk_next = chunk_reg;
        slc_next   = slc_reg;
        wc_next    = wc_reg;
        base_next  = base_reg;
        wi_next    = wi_reg;
        do_finish  = 1'b0;
        q_push     = 1'b0;
        q_wdata          = '0;
        q_wdata.head     = HEAD_NONE;
        q_wdata.tail     = TAIL_POLL;
        q_wdata.lba      = lba_reg[27:0];
        q_wdata.count    = chunk_reg[7:0];
        q_wdata.dir      = dir_reg;
        if (accept) begin
            case (s_mode)
                MODE_START: begin
                    q_push     = 1'b1;
                    dir_next   = s_write_dir;
                    lba_next   = start_lba;
                    total_next = s_sector_count;
                    wi_next    = '0;
                    if (s_sector_count == 32'd0) begin
                        phase_next   = PH_IDLE;
                        q_wdata.tail = TAIL_DONE;
                    end else begin
                        chunk_next = chunk_of(s_sector_count);
                        slc_next   = chunk_of(s_sector_count);
                        base_next  = '0;
                        wc_next    = '0;
                        phase_next = PH_BSY_PRE;
                    end
                end
                MODE_STATUS: begin
                    case (phase_reg)
                        PH_BSY_PRE: begin
                            q_push = 1'b1;
                            if (!s_status_byte[ST_BSY_BIT]) begin
                                q_wdata.head = HEAD_CMD;
                                wc_next      = '0;
                                phase_next   = PH_DRQ;
                            end
                        end
                        PH_DRQ: begin
                            q_push = 1'b1;
                            if (s_status_byte[ST_DF_BIT] || s_status_byte[ST_ERR_BIT]) begin
                                q_wdata.head     = HEAD_ABORT;
                                q_wdata.head_val = {8'd0, s_status_byte};
                                q_wdata.head_idx = base_reg;
                                do_finish        = 1'b1;
                            end else if (s_status_byte[ST_DRQ_BIT]) begin
                                if (dir_reg) begin
                                    phase_next       = PH_WDATA;
                                    q_wdata.tail     = TAIL_NEED;
                                    q_wdata.tail_idx = wi_reg;
                                end else begin
                                    phase_next   = PH_RDATA;
                                    q_wdata.tail = TAIL_RREQ;
                                end
                            end
                        end
                        PH_FLUSH: begin
                            q_push = 1'b1;
                            if (!s_status_byte[ST_BSY_BIT]) do_finish = 1'b1;
                        end
                        default: ;
                    endcase
                end
                MODE_DATA: begin
                    if (phase_reg == PH_RDATA || phase_reg == PH_WDATA) begin
                        q_push           = 1'b1;
                        q_wdata.head_val = s_data_word;
                        if (phase_reg == PH_WDATA) begin
                            q_wdata.head = HEAD_WORD_WR;
                        end else begin
                            q_wdata.head     = HEAD_WORD_OUT;
                            q_wdata.head_idx = wi_reg;
                        end
                        wi_next = wi_inc;
                        if (wc_reg != 8'hFF) begin
                            wc_next = wc_reg + 8'd1;
                            if (phase_reg == PH_WDATA) begin
                                q_wdata.tail     = TAIL_NEED;
                                q_wdata.tail_idx = wi_inc;
                            end else begin
                                q_wdata.tail = TAIL_RREQ;
                            end
                        end else begin
                            // sector complete
                            wc_next  = '0;
                            slc_next = slc_dec;
                            if (slc_dec != 9'd0) begin
                                phase_next = PH_DRQ;
                            end else if (dir_reg) begin
                                phase_next   = PH_FLUSH;
                                q_wdata.tail = TAIL_FLUSH;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (do_finish) begin
                lba_next   = fin_lba;
                total_next = fin_total;
                wi_next    = fin_wi;
                if (fin_total == 32'd0) begin
                    phase_next       = PH_IDLE;
                    q_wdata.tail     = TAIL_DONE;
                    q_wdata.tail_idx = fin_wi;
                end else begin
                    chunk_next   = chunk_of(fin_total);
                    slc_next     = chunk_of(fin_total);
                    base_next    = fin_wi;
                    wc_next      = '0;
                    phase_next   = PH_BSY_PRE;
                    q_wdata.tail = TAIL_POLL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            dir_reg   <= 1'b0;
            part_reg  <= '0;
            lba_reg   <= '0;
            total_reg <= '0;
            chunk_reg <= '0;
            slc_reg   <= '0;
            wc_reg    <= '0;
            base_reg  <= '0;
            wi_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            if (cfg_we) part_reg <= cfg_wdata;
            lba_reg   <= lba_next;
            total_reg <= total_next;
            chunk_reg <= chunk_next;
            slc_reg   <= slc_next;
            wc_reg    <= wc_next;
            base_reg  <= base_next;
            wi_reg    <= wi_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ata_pio_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO descriptor queue
// Short first-in first-out store between front and back end.
// ----------------------------------------------------------------------------
module ata_pio_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ata_pio_pkg::desc_t  wdata,
    output logic                     full,
    input  wire logic                pop,
    output logic                     valid,
    output ata_pio_pkg::desc_t       rdata
);
    import ata_pio_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    desc_t          mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]    count_reg;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full  = count_reg == (PW+1)'(QDEPTH);
    assign valid = count_reg != '0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push) count_reg <= count_reg - (PW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ata_pio_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO back end
// Expands each queued descriptor into its result words, one per cycle while m_ready does not hold the output.
// ----------------------------------------------------------------------------
module ata_pio_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire ata_pio_pkg::desc_t  q_rdata,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_action,
    output logic [2:0]               m_reg_offset,
    output logic [15:0]              m_value,
    output logic [39:0]              m_buffer_index,
    output logic                     m_last
);
    import ata_pio_pkg::*;

    logic [2:0]  step_reg;
    logic        m_valid_reg;
    logic [2:0]  act_reg, off_reg;
    logic [15:0] val_reg;
    logic [39:0] idx_reg;
    logic        last_reg;

    logic [2:0]  head_len, tail_len, total, tstep;
    logic        load, is_last;
    logic [2:0]  act_n, off_n;
    logic [15:0] val_n;
    logic [39:0] idx_n;

    always_comb begin
        case (q_rdata.head)
            HEAD_CMD:                               head_len = 3'd6;
            HEAD_ABORT, HEAD_WORD_OUT, HEAD_WORD_WR: head_len = 3'd1;
            default:                                head_len = 3'd0;
        endcase
        tail_len = (q_rdata.tail == TAIL_FLUSH) ? 3'd2 : 3'd1;
    end

    assign total   = head_len + tail_len;
    assign tstep   = step_reg - head_len;
    assign is_last = step_reg == total - 3'd1;
    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = load && is_last;

    always_comb begin
        act_n = ACT_STAT_RD;
        off_n = OFF_CMD;
        val_n = '0;
        idx_n = '0;
        if (step_reg < head_len) begin
            case (q_rdata.head)
                HEAD_CMD: begin
                    act_n = ACT_REG_WR;
                    case (step_reg)
                        3'd0: begin off_n = OFF_COUNT;   val_n = {8'd0, q_rdata.count};      end
                        3'd1: begin off_n = OFF_LBA_LO;  val_n = {8'd0, q_rdata.lba[7:0]};   end
                        3'd2: begin off_n = OFF_LBA_MID; val_n = {8'd0, q_rdata.lba[15:8]};  end
                        3'd3: begin off_n = OFF_LBA_HI;  val_n = {8'd0, q_rdata.lba[23:16]}; end
                        3'd4: begin
                            off_n = OFF_DRIVE;
                            val_n = {8'd0, DRIVE_LBA | {4'd0, q_rdata.lba[27:24]}};
                        end
                        default: begin
                            off_n = OFF_CMD;
                            val_n = {8'd0, q_rdata.dir ? CMD_WRITE : CMD_READ};
                        end
                    endcase
                end
                HEAD_ABORT: begin
                    act_n = ACT_ABORT; off_n = OFF_DATA;
                    val_n = q_rdata.head_val; idx_n = q_rdata.head_idx;
                end
                HEAD_WORD_OUT: begin
                    act_n = ACT_WORD_OUT; off_n = OFF_DATA;
                    val_n = q_rdata.head_val; idx_n = q_rdata.head_idx;
                end
                default: begin
                    act_n = ACT_DATA_WR; off_n = OFF_DATA; val_n = q_rdata.head_val;
                end
            endcase
        end else begin
            case (q_rdata.tail)
                TAIL_DONE: begin
                    act_n = ACT_DONE; off_n = OFF_DATA; idx_n = q_rdata.tail_idx;
                end
                TAIL_NEED: begin
                    act_n = ACT_NEED_WORD; off_n = OFF_DATA; idx_n = q_rdata.tail_idx;
                end
                TAIL_RREQ: begin
                    act_n = ACT_DATA_RD; off_n = OFF_DATA;
                end
                TAIL_FLUSH: begin
                    if (tstep == 3'd0) begin
                        act_n = ACT_REG_WR; val_n = {8'd0, CMD_FLUSH};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            step_reg    <= is_last ? 3'd0 : step_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            act_reg  <= act_n;
            off_reg  <= off_n;
            val_reg  <= val_n;
            idx_reg  <= idx_n;
            last_reg <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_action       = act_reg;
    assign m_reg_offset   = off_reg;
    assign m_value        = val_reg;
    assign m_buffer_index = idx_reg;
    assign m_last         = last_reg;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> step_reg < total)
        else $error("step beyond descriptor length");
    a_step_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> step_reg == 3'd0)
        else $error("step left mid-descriptor with queue empty");
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && act_reg == ACT_DONE |-> last_reg)
        else $error("done word not marked last");
    a_pop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> step_reg == 3'd0)
        else $error("step not cleared after pop");
`endif

endmodule
`default_nettype wire

// ----- hdl/ata_pio_transfer_sequencer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer
// Host-side LBA28 PIO engine: chunking, task-file writes, polling, data moves.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle, stalling only when the queue is
// full, and updates the transfer state at once; each item its phase accepts
// yields a descriptor in a two-entry queue, and the back end emits result
// words at one word per cycle while m_ready does not hold the output. Results
// per item: two for most data words, one for a poll, seven for the task-file
// burst that starts a chunk; the back end has a single output register stage.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer_unit #(
    parameter int CHUNK_SECTORS = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_mode,
    input  wire logic         s_write_dir,
    input  wire logic         s_use_partition,
    input  wire logic [31:0]  s_lba,
    input  wire logic [31:0]  s_sector_count,
    input  wire logic [7:0]   s_status_byte,
    input  wire logic [15:0]  s_data_word,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_action,
    output logic [2:0]        m_reg_offset,
    output logic [15:0]       m_value,
    output logic [39:0]       m_buffer_index,
    output logic              m_last
);
    import ata_pio_pkg::*;

    logic  q_full, q_push, q_valid, q_pop;
    desc_t q_wdata, q_rdata;

    ata_pio_front #(.CHUNK_SECTORS(CHUNK_SECTORS)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_mode, .s_write_dir, .s_use_partition,
        .s_lba, .s_sector_count, .s_status_byte, .s_data_word,
        .q_full, .q_push, .q_wdata
    );

    ata_pio_fifo u_fifo (
        .aclk, .aresetn,
        .push(q_push), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .valid(q_valid), .rdata(q_rdata)
    );

    ata_pio_back u_back (
        .aclk, .aresetn, .q_valid, .q_rdata, .q_pop,
        .m_valid, .m_ready, .m_action, .m_reg_offset, .m_value,
        .m_buffer_index, .m_last
    );

endmodule
`default_nettype wire
